>>> hdl/pss_pkg.sv
// Shared types, codes and helpers of the periodic send scheduler.
`default_nettype none
package pss_pkg;

	localparam int MAX_ENTRIES_DEF = 64;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ADD   = 2'd1;
	localparam logic [1:0] OP_NEXT  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic [62:0] DUE_MAX = {63{1'b1}};

	typedef struct packed {
		logic [1:0]  op;
		logic [30:0] source_id;
		logic [31:0] period;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [30:0] sent_id;
		logic [62:0] send_time;
	} rsp_t;

	typedef struct packed {
		logic [30:0] id;
		logic [62:0] due;
		logic [31:0] per;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_NXT_ROOT,
		S_SD_RD,
		S_SD_CMP,
		S_PUSH,
		S_SU_RD,
		S_SU_CMP
	} state_t;

	// heap order: due time first, then identifier
	function automatic logic key_less(entry_t a, entry_t b);
		return {a.due, a.id} < {b.due, b.id};
	endfunction

endpackage
`default_nettype wire

>>> hdl/pss_ram.sv
// Heap entry store: one write port, two registered read ports.
`default_nettype none
module pss_ram #(
	parameter int DEPTH = pss_pkg::MAX_ENTRIES_DEF
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire  [$clog2(DEPTH)-1:0]  waddr,
	input  pss_pkg::entry_t           wdata,
	input  wire  [$clog2(DEPTH)-1:0]  raddr_a,
	input  wire  [$clog2(DEPTH)-1:0]  raddr_b,
	output pss_pkg::entry_t           rdata_a,
	output pss_pkg::entry_t           rdata_b
);
	import pss_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
`default_nettype wire

>>> hdl/periodic_send_scheduler_top.sv
// Periodic send scheduler: min-heap of sources walked by a small sequencer.
// Clear, unknown op, full add and empty next go straight from idle to done with a status.
// Add appends the source and sifts it up until a compare stops it or it reaches the root.
// Next pops the root, sifts the last entry down, then re-adds the root, due advanced by its
// period; with one source it skips the sift-down. Each level is a RAM read then a compare/write.
// Busy while the sequencer runs; results never stall. Reset clears count, sequencer and done only.
`default_nettype none
module periodic_send_scheduler_top #(
	parameter int MAX_ENTRIES = pss_pkg::MAX_ENTRIES_DEF
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           start,
	input  pss_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output pss_pkg::rsp_t rsp
);
	import pss_pkg::*;

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int LW = AW + 2;

	state_t          state_q, state_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [AW-1:0]   pos_q, pos_d;
	entry_t          x_q, x_d;
	entry_t          ins_q, ins_d;
	rsp_t            res_q, res_d;
	logic            done_q, done_d;

	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	entry_t          wr_data;
	logic [AW-1:0]   rd_addr_a, rd_addr_b;
	entry_t          rd_a, rd_b;

	logic [LW-1:0]   left, right;
	logic            right_ok, pick_b, best_less;
	logic [AW-1:0]   parent;
	logic [63:0]     due_sum;
	logic [62:0]     due_next;

	pss_ram #(
		.DEPTH(MAX_ENTRIES)
	) u_ram (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (wr_addr),
		.wdata   (wr_data),
		.raddr_a (rd_addr_a),
		.raddr_b (rd_addr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	assign left      = {1'b0, pos_q, 1'b1};
	assign right     = left + LW'(1);
	assign right_ok  = right < LW'(cnt_q);
	assign pick_b    = right_ok && key_less(rd_b, rd_a);
	assign best_less = pick_b ? key_less(rd_b, x_q) : key_less(rd_a, x_q);
	assign parent    = AW'((pos_q - AW'(1)) >> 1);
	assign due_sum   = {1'b0, rd_a.due} + 64'(rd_a.per);
	assign due_next  = due_sum[63] ? DUE_MAX : due_sum[62:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		x_q   <= x_d;
		ins_q <= ins_d;
		res_q <= res_d;
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		pos_d     = pos_q;
		x_d       = x_q;
		ins_d     = ins_q;
		res_d     = res_q;
		done_d    = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = pos_q;
		wr_data   = x_q;
		rd_addr_a = left[AW-1:0];
		rd_addr_b = right[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					res_d = '0;
					case (req.op)
						OP_CLEAR: begin
							cnt_d  = '0;
							done_d = 1'b1;
						end
						OP_ADD: begin
							if (cnt_q == CW'(MAX_ENTRIES)) begin
								res_d.status = ST_FULL;
								done_d       = 1'b1;
							end else begin
								ins_d   = '{id: req.source_id, due: 63'(req.period),
									per: req.period};
								state_d = S_PUSH;
							end
						end
						OP_NEXT: begin
							if (cnt_q == '0) begin
								res_d.status = ST_EMPTY;
								done_d       = 1'b1;
							end else begin
								rd_addr_a = '0;
								rd_addr_b = AW'(cnt_q - CW'(1));
								state_d   = S_NXT_ROOT;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			S_NXT_ROOT: begin
				res_d.sent_id   = rd_a.id;
				res_d.send_time = rd_a.due;
				ins_d           = '{id: rd_a.id, due: due_next, per: rd_a.per};
				cnt_d           = cnt_q - CW'(1);
				x_d             = rd_b;
				pos_d           = '0;
				state_d         = (cnt_q == CW'(1)) ? S_PUSH : S_SD_RD;
			end
			S_SD_RD: begin
				if (left >= LW'(cnt_q)) begin
					wr_en   = 1'b1;
					state_d = S_PUSH;
				end else begin
					state_d = S_SD_CMP;
				end
			end
			S_SD_CMP: begin
				wr_en = 1'b1;
				if (best_less) begin
					wr_data = pick_b ? rd_b : rd_a;
					pos_d   = pick_b ? right[AW-1:0] : left[AW-1:0];
					state_d = S_SD_RD;
				end else begin
					state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				pos_d   = cnt_q[AW-1:0];
				cnt_d   = cnt_q + CW'(1);
				x_d     = ins_q;
				state_d = S_SU_RD;
			end
			S_SU_RD: begin
				rd_addr_a = parent;
				if (pos_q == '0) begin
					wr_en   = 1'b1;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_SU_CMP;
				end
			end
			S_SU_CMP: begin
				wr_en = 1'b1;
				if (key_less(x_q, rd_a)) begin
					wr_data = rd_a;
					pos_d   = parent;
					state_d = S_SU_RD;
				end else begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = res_q;

endmodule
`default_nettype wire
